@@ rtl/ssfs_pkg.sv @@
// shared types, constants and the segment table for the frame sequencer
// no dependencies
`default_nettype none

package ssfs_pkg;

    localparam int VALUE_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int DIGIT_W   = 4;
    localparam int BCD_W     = 20;
    localparam int QUEUE_D   = 2;
    localparam int QPTR_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CONTROL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE    = 8'd1;

    localparam logic [BYTE_W-1:0] CTRL_RESET      = 8'h8D;
    localparam logic [BYTE_W-1:0] MODE_RESET      = 8'h00;
    localparam logic [BYTE_W-1:0] AUTO_INC_CMD    = 8'h40;
    localparam logic [BYTE_W-1:0] START_ADDR_CMD  = 8'hC0;
    localparam logic [BYTE_W-1:0] ZERO_BYTE       = 8'h00;

    typedef struct packed {
        logic [DIGIT_W-1:0] d3;
        logic [DIGIT_W-1:0] d2;
        logic [DIGIT_W-1:0] d1;
        logic [DIGIT_W-1:0] d0;
    } t_digits;

    typedef enum logic [3:0] {
        S_MODE,
        S_AUTO,
        S_ADDR,
        S_D3,
        S_Z3,
        S_D2,
        S_Z2,
        S_D1,
        S_Z1,
        S_D0,
        S_Z0,
        S_CTRL
    } t_slot;

    function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [BYTE_W-1:0] c;
        case (d)
            4'd0:    c = 8'h3F;
            4'd1:    c = 8'h06;
            4'd2:    c = 8'h5B;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h66;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h7D;
            4'd7:    c = 8'h07;
            4'd8:    c = 8'h7F;
            4'd9:    c = 8'h6F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ssfs_if.sv @@
// channel interfaces: value input, byte output and configuration write
// depends on ssfs_pkg
`default_nettype none

interface ssfs_value_if;
    import ssfs_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface ssfs_byte_if;
    import ssfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;
    logic              frame_start;
    logic              frame_end;
    logic              last;
    modport source (output valid, output byte_out, output frame_start,
                    output frame_end, output last, input ready);
    modport sink   (input valid, input byte_out, input frame_start,
                    input frame_end, input last, output ready);
endinterface

interface ssfs_cfg_if;
    import ssfs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/seven_segment_frame_sequencer_unit.sv @@
// top level: value to twelve-byte display command sequence
// a value passes front conversion, queue and byte register, then one byte per cycle
// leaves while digits are queued and the output is ready; twelve slots per value
// the front digit conversion runs ahead through a 2-entry queue
// synchronous active-low reset clears control state and loads register defaults
// depends on ssfs_pkg, ssfs_if, ssfs_front, ssfs_queue, ssfs_back
`default_nettype none

module seven_segment_frame_sequencer_unit
    import ssfs_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    ssfs_value_if.sink   i_value,
    ssfs_cfg_if.sink     i_cfg,
    ssfs_byte_if.source  o_byte
);

    logic    w_push, w_full, w_pop, w_empty;
    t_digits w_push_digits, w_head_digits;

    ssfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .o_push   (w_push),
        .o_digits (w_push_digits),
        .i_full   (w_full)
    );

    ssfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_digits (w_push_digits),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_digits (w_head_digits),
        .o_empty  (w_empty)
    );

    ssfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_digits (w_head_digits),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_byte   (o_byte)
    );

endmodule

`default_nettype wire

@@ rtl/ssfs_front.sv @@
// front end: accepts a value and converts it to four decimal digits
// shift-and-add-3 conversion, two bits per cycle; depends on ssfs_pkg, ssfs_if
`default_nettype none

module ssfs_front
    import ssfs_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    ssfs_value_if.sink i_value,
    output logic       o_push,
    output t_digits    o_digits,
    input  wire        i_full
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [2:0]         r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic               w_accept;
    logic [BCD_W-1:0]   w_mid;

    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic bit_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int i = 0; i < BCD_W / DIGIT_W; i++) begin
            if (a[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                a[i*DIGIT_W +: DIGIT_W] = a[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    assign i_value.ready = !r_busy && !r_done;
    assign w_accept      = i_value.valid && i_value.ready;
    assign o_push        = r_done && !i_full;
    assign o_digits      = '{d3: r_bcd[15:12], d2: r_bcd[11:8],
                             d1: r_bcd[7:4],   d0: r_bcd[3:0]};
    assign w_mid         = dd_step(r_bcd, r_bin[VALUE_W-1]);

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (w_accept) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_bin  = i_value.value;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd = dd_step(w_mid, r_bin[VALUE_W-2]);
            n_bin = {r_bin[VALUE_W-3:0], 2'b00};
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (o_push) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

endmodule

`default_nettype wire

@@ rtl/ssfs_queue.sv @@
// two-entry digit queue between front end and byte sequencer
// depends on ssfs_pkg
`default_nettype none

module ssfs_queue
    import ssfs_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_push,
    input  t_digits  i_digits,
    output logic     o_full,
    input  wire      i_pop,
    output t_digits  o_digits,
    output logic     o_empty
);

    t_digits           r_mem [QUEUE_D];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;

    assign o_full   = (r_count == QUEUE_D[QPTR_W:0]);
    assign o_empty  = (r_count == '0);
    assign o_digits = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssfs_back.sv @@
// byte sequencer: walks the twelve-byte frame sequence per digit set
// holds the configuration registers; depends on ssfs_pkg, ssfs_if
`default_nettype none

module ssfs_back
    import ssfs_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    ssfs_cfg_if.sink     i_cfg,
    input  t_digits      i_digits,
    input  wire          i_empty,
    output logic         o_pop,
    ssfs_byte_if.source  o_byte
);

    t_slot             r_slot, n_slot;
    logic [BYTE_W-1:0] r_ctrl, r_mode;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_fs, n_fs;
    logic              r_fe, n_fe;
    logic              r_last, n_last;
    logic              w_load;

    assign i_cfg.ready = 1'b1;
    assign w_load      = !i_empty && (!r_valid || o_byte.ready);
    assign o_pop       = w_load && (r_slot == S_CTRL);

    always_comb begin
        n_slot = r_slot;
        if (w_load) begin
            n_slot = (r_slot == S_CTRL) ? S_MODE : t_slot'(r_slot + 4'd1);
        end
    end

    always_comb begin
        n_byte = ZERO_BYTE;
        n_fs   = 1'b0;
        n_fe   = 1'b0;
        n_last = 1'b0;
        case (r_slot)
            S_MODE: begin
                n_byte = r_mode;
                n_fs   = 1'b1;
                n_fe   = 1'b1;
            end
            S_AUTO: begin
                n_byte = AUTO_INC_CMD;
                n_fs   = 1'b1;
                n_fe   = 1'b1;
            end
            S_ADDR: begin
                n_byte = START_ADDR_CMD;
                n_fs   = 1'b1;
            end
            S_D3:   n_byte = seg_code(i_digits.d3);
            S_D2:   n_byte = seg_code(i_digits.d2);
            S_D1:   n_byte = seg_code(i_digits.d1);
            S_D0:   n_byte = seg_code(i_digits.d0);
            S_Z0:   n_fe   = 1'b1;
            S_CTRL: begin
                n_byte = r_ctrl;
                n_fs   = 1'b1;
                n_fe   = 1'b1;
                n_last = 1'b1;
            end
            default: n_byte = ZERO_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= S_MODE;
            r_valid <= 1'b0;
            r_ctrl  <= CTRL_RESET;
            r_mode  <= MODE_RESET;
        end else begin
            r_slot <= n_slot;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_DISPLAY_CONTROL) begin
                    r_ctrl <= i_cfg.data;
                end else if (i_cfg.index == CFG_DISPLAY_MODE) begin
                    r_mode <= i_cfg.data;
                end
            end
        end
        if (w_load) begin
            r_byte <= n_byte;
            r_fs   <= n_fs;
            r_fe   <= n_fe;
            r_last <= n_last;
        end
    end

    assign o_byte.valid       = r_valid;
    assign o_byte.byte_out    = r_byte;
    assign o_byte.frame_start = r_fs;
    assign o_byte.frame_end   = r_fe;
    assign o_byte.last        = r_last;

endmodule

`default_nettype wire
